[rtl/tme_pkg.sv]
// ----------------------------------------------------------------------------
// tme_pkg
// Shared types and constants of the tape machine execute unit: tape and loop
// stack geometry, instruction characters, status codes and the result word.
// ----------------------------------------------------------------------------
package tme_pkg;

  // Geometry
  localparam int unsigned TAPE_DEPTH = 32768;
  localparam int unsigned TP_W       = $clog2(TAPE_DEPTH);
  localparam int unsigned FILL_W     = TP_W + 1;
  localparam int unsigned LOOP_DEPTH = 256;
  localparam int unsigned LS_W       = $clog2(LOOP_DEPTH);
  localparam int unsigned LC_W       = LS_W + 1;
  localparam int unsigned PC_W       = 16;
  localparam int unsigned SKIP_W     = 16;

  // Stream word widths
  localparam int unsigned S_DATA_W   = 32;
  localparam int unsigned M_DATA_W   = 32;

  // Instruction characters
  localparam logic [7:0] CH_INC   = 8'd43;
  localparam logic [7:0] CH_DEC   = 8'd45;
  localparam logic [7:0] CH_RIGHT = 8'd62;
  localparam logic [7:0] CH_LEFT  = 8'd60;
  localparam logic [7:0] CH_OPEN  = 8'd91;
  localparam logic [7:0] CH_CLOSE = 8'd93;
  localparam logic [7:0] CH_OUT   = 8'd46;
  localparam logic [7:0] CH_IN    = 8'd44;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNMATCHED  = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_UNDERFLOW  = 3'd3,
    ST_STACK_FULL = 3'd4,
    ST_ABORTED    = 3'd5
  } status_e;

  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            out_valid;
    logic [7:0]      out_byte;
    status_e         status;
  } res_t;

endpackage

[rtl/tme_exec.sv]
// ----------------------------------------------------------------------------
// tme_exec
// Execution core: tape and loop stack memories, cached current cell and stack
// top, pointer, fill count, skip depth and abort flag. One instruction per
// accepted word, result produced combinationally in the accept cycle.
// ----------------------------------------------------------------------------
module tme_exec (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [7:0]                  func_i,
  input  logic [tme_pkg::PC_W-1:0]    pc_i,
  input  logic [7:0]                  in_byte_i,
  output tme_pkg::res_t               res_o
);
  import tme_pkg::*;

  // Memories
  logic [7:0]      tape_mem [TAPE_DEPTH];
  logic [PC_W-1:0] stk_mem  [LOOP_DEPTH];

  // State
  logic [TP_W-1:0]   tp_q, tp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [LC_W-1:0]   cnt_q, cnt_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic              abort_q, abort_d;
  logic [7:0]        cell_q, cell_d;
  logic [PC_W-1:0]   top_q, top_d;
  logic              ld_pend_q, ld_pend_d;
  logic              stk_pend_q, stk_pend_d;
  logic [7:0]        tape_rd_q;
  logic [PC_W-1:0]   stk_rd_q;

  // Memory port controls
  logic              tape_we, tape_re;
  logic [TP_W-1:0]   tape_waddr, tape_raddr;
  logic              stk_we, stk_re;
  logic [LS_W-1:0]   stk_waddr, stk_raddr;

  // Effective cell and stack top, forwarded from a read issued last cycle
  logic [7:0]        cur_cell;
  logic [PC_W-1:0]   top;
  logic [LC_W-1:0]   cnt_m2;
  logic              tp_beyond;

  assign cur_cell  = ld_pend_q  ? tape_rd_q : cell_q;
  assign top       = stk_pend_q ? stk_rd_q  : top_q;
  assign cnt_m2    = cnt_q - LC_W'(2);
  assign tp_beyond = ({1'b0, tp_q} == fill_q);

  // Instruction decode and state update
  always_comb begin
    tp_d       = tp_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    abort_d    = abort_q;
    cell_d     = cur_cell;
    top_d      = top;
    ld_pend_d  = 1'b0;
    stk_pend_d = 1'b0;
    tape_we    = 1'b0;
    tape_re    = 1'b0;
    tape_waddr = tp_q;
    tape_raddr = tp_q;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    stk_waddr  = cnt_q[LS_W-1:0];
    stk_raddr  = cnt_m2[LS_W-1:0];

    res_o.next_pc   = pc_i + PC_W'(1);
    res_o.out_valid = 1'b0;
    res_o.out_byte  = 8'd0;
    res_o.status    = ST_OK;

    if (abort_q) begin
      res_o.next_pc = pc_i;
      res_o.status  = ST_ABORTED;
    end else if (skip_q != '0) begin
      // Forward skip: only track bracket nesting
      if (accept_i && func_i == CH_OPEN && skip_q != '1) begin
        skip_d = skip_q + SKIP_W'(1);
      end else if (accept_i && func_i == CH_CLOSE) begin
        skip_d = skip_q - SKIP_W'(1);
      end
    end else begin
      case (func_i)
        CH_INC: cell_d = cur_cell + 8'd1;
        CH_DEC: cell_d = cur_cell - 8'd1;
        CH_IN:  cell_d = in_byte_i;
        CH_OUT: begin
          res_o.out_valid = 1'b1;
          res_o.out_byte  = cur_cell;
        end
        CH_RIGHT: begin
          if (tp_q == TP_W'(TAPE_DEPTH - 1)) begin
            abort_d      = 1'b1;
            res_o.status = ST_OVERFLOW;
          end else begin
            // write back current cell, fetch the next one if ever stored
            tape_we    = accept_i;
            tp_d       = tp_q + TP_W'(1);
            tape_raddr = tp_q + TP_W'(1);
            if (tp_beyond) begin
              fill_d = fill_q + FILL_W'(1);
              cell_d = 8'd0;
            end else if ({1'b0, tp_q} + FILL_W'(1) == fill_q) begin
              cell_d = 8'd0;
            end else begin
              tape_re   = accept_i;
              ld_pend_d = 1'b1;
            end
          end
        end
        CH_LEFT: begin
          if (tp_q == '0) begin
            abort_d      = 1'b1;
            res_o.status = ST_UNDERFLOW;
          end else begin
            tape_we    = accept_i;
            tp_d       = tp_q - TP_W'(1);
            tape_raddr = tp_q - TP_W'(1);
            tape_re    = accept_i;
            ld_pend_d  = 1'b1;
            if (tp_beyond) begin
              fill_d = fill_q + FILL_W'(1);
            end
          end
        end
        CH_OPEN: begin
          if (cnt_q == LC_W'(LOOP_DEPTH)) begin
            abort_d      = 1'b1;
            res_o.status = ST_STACK_FULL;
          end else if (cur_cell != 8'd0) begin
            stk_we = accept_i;
            cnt_d  = cnt_q + LC_W'(1);
            top_d  = pc_i;
          end else begin
            skip_d = SKIP_W'(1);
          end
        end
        CH_CLOSE: begin
          if (cnt_q == '0) begin
            res_o.status = ST_UNMATCHED;
          end else if (cur_cell != 8'd0) begin
            res_o.next_pc = top + PC_W'(1);
          end else begin
            // pop, refetch the entry below as new top
            cnt_d      = cnt_q - LC_W'(1);
            stk_re     = accept_i;
            stk_pend_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Without an accepted word only the forwarded values fold into the cache
    if (!accept_i) begin
      tp_d       = tp_q;
      fill_d     = fill_q;
      cnt_d      = cnt_q;
      skip_d     = skip_q;
      abort_d    = abort_q;
      cell_d     = cur_cell;
      top_d      = top;
      ld_pend_d  = 1'b0;
      stk_pend_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q       <= '0;
      fill_q     <= '0;
      cnt_q      <= '0;
      skip_q     <= '0;
      abort_q    <= 1'b0;
      cell_q     <= 8'd0;
      ld_pend_q  <= 1'b0;
      stk_pend_q <= 1'b0;
    end else begin
      tp_q       <= tp_d;
      fill_q     <= fill_d;
      cnt_q      <= cnt_d;
      skip_q     <= skip_d;
      abort_q    <= abort_d;
      cell_q     <= cell_d;
      ld_pend_q  <= ld_pend_d;
      stk_pend_q <= stk_pend_d;
    end
  end

  // Cached stack top, only meaningful while the stack is not empty
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // Tape memory
  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= cur_cell;
    end
    if (tape_re) begin
      tape_rd_q <= tape_mem[tape_raddr];
    end
  end

  // Loop stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= pc_i;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

endmodule

[rtl/tape_machine_execute_unit_top.sv]
// ----------------------------------------------------------------------------
// tape_machine_execute_unit_top
// Stream wrapper of the tape machine execute unit with a registered output.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one instruction word: character, program
//   position and input byte. For each accepted word exactly one result word
//   leaves on the master channel: next program position, output byte flag,
//   output byte and status.
//   m_axis_tvalid_o is set in the cycle after an accept. Throughput is one
//   word per cycle unless the receiver stalls: the current tape cell and the
//   loop stack top are cached in registers, and the single tape or stack
//   read of a pointer move or a pop is forwarded to the next instruction.
//   Reset clears pointer, stack count, skip depth and abort flag; the tape
//   reads as zero through a fill count of cells ever stored, so no clearing
//   pass runs and words are taken from the first cycle after reset.
//   When the receiver stalls, the result stays in the output register and
//   s_axis_tready_o drops until it is taken; a new word is accepted in the
//   same cycle the old result leaves.
// ----------------------------------------------------------------------------
module tape_machine_execute_unit_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] func, [23:8] pc, [31:24] in_byte
  input  logic [tme_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] next_pc, [16] out_valid, [24:17] out_byte, [27:25] status, zero
  output logic [tme_pkg::M_DATA_W-1:0]  m_axis_tdata_o
);
  import tme_pkg::*;

  logic                accept;
  res_t                res;
  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q;

  // Accept whenever the output register is free or drains now
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  tme_exec u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .func_i    (s_axis_tdata_i[7:0]),
    .pc_i      (s_axis_tdata_i[23:8]),
    .in_byte_i (s_axis_tdata_i[31:24]),
    .res_o     (res)
  );

  // Output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (accept) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= {4'd0, res.status, res.out_byte, res.out_valid, res.next_pc};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

[rtl/tme_checker.sv]
// ----------------------------------------------------------------------------
// tme_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module tme_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [tme_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [tme_pkg::M_DATA_W-1:0]  m_axis_tdata_o
);
  import tme_pkg::*;

  // Result word held while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed under stall");

  // Every accepted instruction shows a result the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

  // An aborted machine emits no byte and holds its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=>
      m_axis_tdata_o[27:25] != ST_ABORTED ||
      (m_axis_tdata_o[16] == 1'b0 && m_axis_tdata_o[15:0] == $past(s_axis_tdata_i[23:8])))
    else $error("aborted result not frozen");

  // Byte field is zero unless a byte is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[16] |-> m_axis_tdata_o[24:17] == 8'd0)
    else $error("output byte without flag");

  // Once aborted, aborted for good: checked on a result directly behind a taken aborted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o[27:25] == ST_ABORTED
      ##1 m_axis_tvalid_o |-> m_axis_tdata_o[27:25] == ST_ABORTED)
    else $error("abort flag not sticky");

endmodule

bind tape_machine_execute_unit_top tme_checker u_tme_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
